// ----- rtl/core/wsfd_pkg.sv -----
// ----------------------------------------------------------------------------
// WebSocket frame deframer package
// Shared codes, types and helper functions for the deframer block.
// ----------------------------------------------------------------------------
package wsfd_pkg;

    localparam int unsigned LimitWidth = 21;
    localparam int unsigned LenWidth   = 64;

    // Event kinds carried on the result channel.
    localparam logic [2:0] EV_TEXT   = 3'd0;
    localparam logic [2:0] EV_BIN    = 3'd1;
    localparam logic [2:0] EV_PING   = 3'd2;
    localparam logic [2:0] EV_CLOSED = 3'd3;
    localparam logic [2:0] EV_ERROR  = 3'd4;

    // Frame opcodes of interest.
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;

    // 7-bit length codes that announce an extended length.
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // Header byte counts for the extended length and the masking key.
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    // Register index on the configuration port.
    localparam logic REG_PAYLOAD_LIMIT = 1'b0;

    localparam logic [LimitWidth-1:0] LIMIT_RESET = 21'd4096;

    typedef enum logic [5:0] {
        PH_HDR0 = 6'b000001,
        PH_HDR1 = 6'b000010,
        PH_EXT  = 6'b000100,
        PH_MASK = 6'b001000,
        PH_DATA = 6'b010000,
        PH_STOP = 6'b100000
    } phase_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] event_kind;
        logic [7:0] data_byte;
        logic       has_data;
        logic       last;
    } result_t;

    function automatic logic is_data_op(input logic [3:0] op);
        return (op == OP_TEXT) || (op == OP_BIN) || (op == OP_PING);
    endfunction

    function automatic logic [2:0] data_kind(input logic [3:0] op);
        logic [2:0] kind;
        case (op)
            OP_TEXT: kind = EV_TEXT;
            OP_BIN:  kind = EV_BIN;
            default: kind = EV_PING;
        endcase
        return kind;
    endfunction

endpackage

// ----- rtl/core/wsfd_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// WebSocket deframer configuration registers
// APB-style register file holding the payload length limit.
// ----------------------------------------------------------------------------
module wsfd_cfg_regs (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [2:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    output logic [wsfd_pkg::LimitWidth-1:0]      payload_limit
);

    logic [wsfd_pkg::LimitWidth-1:0] limit_reg;
    logic                            wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == wsfd_pkg::REG_PAYLOAD_LIMIT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= wsfd_pkg::LIMIT_RESET;
        end else if (wr_en) begin
            limit_reg <= pwdata[wsfd_pkg::LimitWidth-1:0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == wsfd_pkg::REG_PAYLOAD_LIMIT) begin
            prdata = {{(32 - wsfd_pkg::LimitWidth){1'b0}}, limit_reg};
        end
    end

    assign payload_limit = limit_reg;

endmodule

// ----- rtl/core/wsfd_parser.sv -----
// ----------------------------------------------------------------------------
// WebSocket deframer frame parser
// Header/payload state machine; one byte per step, at most one result.
// ----------------------------------------------------------------------------
module wsfd_parser (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             step,
    input  logic [7:0]                       rx_byte,
    input  logic [wsfd_pkg::LimitWidth-1:0]  payload_limit,
    output wsfd_pkg::result_t                result
);

    wsfd_pkg::phase_t                phase_reg, phase_next;
    logic [3:0]                      op_reg, op_next;
    logic                            mask_reg, mask_next;
    logic                            ext_long_reg, ext_long_next;
    logic [wsfd_pkg::LenWidth-1:0]   len_reg, len_next;
    logic [3:0]                      cnt_reg, cnt_next;
    logic [31:0]                     key_reg, key_next;
    logic [wsfd_pkg::LimitWidth-1:0] pos_reg, pos_next;

    logic [wsfd_pkg::LenWidth-1:0]   len_val;
    logic [3:0]                      cnt_inc;
    logic [wsfd_pkg::LimitWidth:0]   pos_inc;
    logic                            is_last;
    logic [7:0]                      key_byte;
    logic                            do_known;
    logic                            do_start;

    assign cnt_inc = cnt_reg + 4'd1;
    assign pos_inc = {1'b0, pos_reg} + {{wsfd_pkg::LimitWidth{1'b0}}, 1'b1};
    // In the payload phase the length already passed the limit check, so its
    // low bits hold all of it.
    assign is_last = pos_inc >= {1'b0, len_reg[wsfd_pkg::LimitWidth-1:0]};

    always_comb begin
        key_byte = 8'd0;
        if (mask_reg) begin
            case (pos_reg[1:0])
                2'd0:    key_byte = key_reg[31:24];
                2'd1:    key_byte = key_reg[23:16];
                2'd2:    key_byte = key_reg[15:8];
                default: key_byte = key_reg[7:0];
            endcase
        end
    end

    always_comb begin
        phase_next    = phase_reg;
        op_next       = op_reg;
        mask_next     = mask_reg;
        ext_long_next = ext_long_reg;
        len_next      = len_reg;
        cnt_next      = cnt_reg;
        key_next      = key_reg;
        pos_next      = pos_reg;
        len_val       = len_reg;
        do_known      = 1'b0;
        do_start      = 1'b0;
        result        = '0;

        case (phase_reg)
            wsfd_pkg::PH_HDR0: begin
                op_next    = rx_byte[3:0];
                phase_next = wsfd_pkg::PH_HDR1;
            end
            wsfd_pkg::PH_HDR1: begin
                mask_next = rx_byte[7];
                if (rx_byte[6:0] == wsfd_pkg::LEN_EXT16 ||
                    rx_byte[6:0] == wsfd_pkg::LEN_EXT64) begin
                    ext_long_next = (rx_byte[6:0] == wsfd_pkg::LEN_EXT64);
                    len_next      = '0;
                    cnt_next      = 4'd0;
                    phase_next    = wsfd_pkg::PH_EXT;
                end else begin
                    len_val  = {{(wsfd_pkg::LenWidth - 7){1'b0}}, rx_byte[6:0]};
                    len_next = len_val;
                    do_known = 1'b1;
                end
            end
            wsfd_pkg::PH_EXT: begin
                len_val  = {len_reg[wsfd_pkg::LenWidth-9:0], rx_byte};
                len_next = len_val;
                cnt_next = cnt_inc;
                if (cnt_inc == (ext_long_reg ? wsfd_pkg::EXT64_BYTES
                                             : wsfd_pkg::EXT16_BYTES)) begin
                    do_known = 1'b1;
                end
            end
            wsfd_pkg::PH_MASK: begin
                key_next = {key_reg[23:0], rx_byte};
                cnt_next = cnt_inc;
                if (cnt_inc == wsfd_pkg::KEY_BYTES) begin
                    do_start = 1'b1;
                end
            end
            wsfd_pkg::PH_DATA: begin
                pos_next = pos_inc[wsfd_pkg::LimitWidth-1:0];
                if (wsfd_pkg::is_data_op(op_reg)) begin
                    result.valid      = 1'b1;
                    result.event_kind = wsfd_pkg::data_kind(op_reg);
                    result.data_byte  = rx_byte ^ key_byte;
                    result.has_data   = 1'b1;
                    result.last       = is_last;
                    if (is_last) begin
                        phase_next = wsfd_pkg::PH_HDR0;
                    end
                end else if (is_last) begin
                    if (op_reg == wsfd_pkg::OP_CLOSE) begin
                        result.valid      = 1'b1;
                        result.event_kind = wsfd_pkg::EV_CLOSED;
                        result.last       = 1'b1;
                        phase_next        = wsfd_pkg::PH_STOP;
                    end else begin
                        phase_next = wsfd_pkg::PH_HDR0;
                    end
                end
            end
            default: begin
                // Stopped: bytes are swallowed until reset.
            end
        endcase

        if (do_known) begin
            if (len_val > {{(wsfd_pkg::LenWidth - wsfd_pkg::LimitWidth){1'b0}},
                           payload_limit}) begin
                result.valid      = 1'b1;
                result.event_kind = wsfd_pkg::EV_ERROR;
                result.last       = 1'b1;
                phase_next        = wsfd_pkg::PH_STOP;
            end else if (mask_next) begin
                cnt_next   = 4'd0;
                key_next   = 32'd0;
                phase_next = wsfd_pkg::PH_MASK;
            end else begin
                do_start = 1'b1;
            end
        end

        if (do_start) begin
            if (len_val != '0) begin
                pos_next   = '0;
                phase_next = wsfd_pkg::PH_DATA;
            end else if (wsfd_pkg::is_data_op(op_reg)) begin
                result.valid      = 1'b1;
                result.event_kind = wsfd_pkg::data_kind(op_reg);
                result.last       = 1'b1;
                phase_next        = wsfd_pkg::PH_HDR0;
            end else if (op_reg == wsfd_pkg::OP_CLOSE) begin
                result.valid      = 1'b1;
                result.event_kind = wsfd_pkg::EV_CLOSED;
                result.last       = 1'b1;
                phase_next        = wsfd_pkg::PH_STOP;
            end else begin
                phase_next = wsfd_pkg::PH_HDR0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= wsfd_pkg::PH_HDR0;
        end else if (step) begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            op_reg       <= op_next;
            mask_reg     <= mask_next;
            ext_long_reg <= ext_long_next;
            len_reg      <= len_next;
            cnt_reg      <= cnt_next;
            key_reg      <= key_next;
            pos_reg      <= pos_next;
        end
    end

endmodule

// ----- rtl/core/websocket_frame_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// WebSocket frame deframer unit
// Parses received RFC 6455 frames byte by byte and delivers unmasked payload.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_valid/s_ready    s_rx_byte[7:0]
//  m_        out        m_valid/m_ready    m_event_kind, m_data_byte, m_has_data, m_last
//  APB       in/out     psel/penable       payload_limit at byte address 0
//
//  Each accepted beat is held in the input register and parsed on its way
//  to the result register, so one beat per cycle is sustained while results
//  are not stalled; any result it makes is registered in the result register.
//  Reset (aresetn low, synchronous) returns the parser to the first header
//  byte, empties both registers and sets payload_limit to 4096.
//  A stalled result only holds back the input register; a new beat is still
//  taken as long as that register is empty or moves on in the same cycle.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // Received byte stream.
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    // Parsed results.
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_kind,
    output logic [7:0]  m_data_byte,
    output logic        m_has_data,
    output logic        m_last,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [wsfd_pkg::LimitWidth-1:0] payload_limit;

    // Input register: holds one beat waiting to be parsed.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Result register.
    logic       out_valid_reg;
    logic [2:0] out_kind_reg;
    logic [7:0] out_data_reg;
    logic       out_has_reg;
    logic       out_last_reg;

    logic              step;
    wsfd_pkg::result_t result;

    wsfd_cfg_regs u_cfg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .payload_limit (payload_limit)
    );

    // The held beat is parsed whenever the result register is free or is
    // being emptied in this cycle, so any result it makes has a place to go.
    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    wsfd_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .rx_byte       (in_byte_reg),
        .payload_limit (payload_limit),
        .result        (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= result.valid;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && result.valid) begin
            out_kind_reg <= result.event_kind;
            out_data_reg <= result.data_byte;
            out_has_reg  <= result.has_data;
            out_last_reg <= result.last;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_event_kind = out_kind_reg;
    assign m_data_byte  = out_data_reg;
    assign m_has_data   = out_has_reg;
    assign m_last       = out_last_reg;

    // A held beat behind a stalled result must not let a new beat in.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |-> !s_ready)
        else $error("input accepted while both registers are full");

    // Closed and error events never carry data and always end their event.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_event_kind == wsfd_pkg::EV_CLOSED ||
                     m_event_kind == wsfd_pkg::EV_ERROR))
        |-> (m_last && !m_has_data && (m_data_byte == 8'd0)))
        else $error("closed or error event with data or without last");

    // A beat without data carries a zero byte and ends its event.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_has_data) |-> (m_data_byte == 8'd0 && m_last))
        else $error("empty result with nonzero byte or without last");

    // A result taken without a parse step leaves the result register empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !step) |=> !m_valid)
        else $error("result register refilled without a parse step");

endmodule
